// ===== src/fixed_point_q24_8_alu_defines.svh =====
// Assertion helpers for the fixed-point ALU
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// same-cycle implication
`define FXALU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fxalu check failed");

// next-cycle implication
`define FXALU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fxalu check failed");

`endif

// ===== src/fxalu_pkg.sv =====
package fxalu_pkg;

    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        ACT_ADD     = 4'd0,
        ACT_SUB     = 4'd1,
        ACT_MUL     = 4'd2,
        ACT_DIV     = 4'd3,
        ACT_CMP     = 4'd4,
        ACT_MIN     = 4'd5,
        ACT_MAX     = 4'd6,
        ACT_INT2FIX = 4'd7,
        ACT_FLT2FIX = 4'd8,
        ACT_FIX2INT = 4'd9,
        ACT_FIX2FLT = 4'd10,
        ACT_INC     = 4'd11,
        ACT_DEC     = 4'd12
    } act_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_FLOAT = 2'd2;

    // per-beat side information that rides along the pipe
    typedef struct packed {
        logic [3:0]  act;
        logic [31:0] result;
        logic        gt;
        logic        lt;
        logic        eq;
        logic [1:0]  status;
        logic        is_div;
        logic        neg;
    } side_t;

    // fixed-to-float front half: magnitude and leading one position
    typedef struct packed {
        logic        sign;
        logic        zero;
        logic [4:0]  lead;
        logic [31:0] mag;
    } cvt_t;

endpackage

// ===== src/fixed_point_q24_8_alu.sv =====
// Signed fixed-point ALU, FRACTION_BITS fraction bits (Q24.8 by default).
// Input channel s_*: one beat per operation; tuser carries the action code,
//   tdata carries operand_a (bits 31:0) and operand_b (bits 63:32).
// Output channel m_*: one beat per input beat, in order; tdata packs
//   result, is_greater, is_less, is_equal and status from bit 0 up.
// Pipeline: front stage (decode, simple ops, 32x32 multiply, float-to-fixed,
//   leading-one search), round stage (product scaling, fixed-to-float
//   rounding), then a chain of 32+FRACTION_BITS divider cells, each cell
//   producing one quotient bit, then the output register.
// Every action passes through every stage, the divider cells included.
// Throughput: one beat per cycle while m_tready stays high; every cell holds its own beat.
// Stall: each stage only holds when it is full and the one after it holds,
//   so bubbles collapse and s_tready drops only once the whole chain is full.
// Reset: all stage valid bits clear; no beats in flight afterwards.
`include "fixed_point_q24_8_alu_defines.svh"

module fixed_point_q24_8_alu #(
    parameter int FRACTION_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [3:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result[31:0], is_greater, is_less, is_equal,
                                   // status[36:35], zero fill
);

    localparam int DW = 32 + FRACTION_BITS;

    // front -> round
    logic                 f_valid, f_ready;
    fxalu_pkg::side_t     f_side;
    fxalu_pkg::cvt_t      f_cvt;
    logic [63:0]          f_prod;
    logic [DW-1:0]        f_dividend;
    logic [31:0]          f_divisor;

    // cell chain taps, index 0 is the round stage output
    logic                 c_valid [0:DW];
    logic                 c_ready [0:DW];
    fxalu_pkg::side_t     c_side  [0:DW];
    logic [31:0]          c_rem   [0:DW];
    logic [DW-1:0]        c_dq    [0:DW];
    logic [31:0]          c_dv    [0:DW];

    // output register
    logic                 o_valid_reg;
    logic [39:0]          o_data_reg, o_data_next;
    logic [31:0]          quot;

    fxalu_front #(
        .FRACTION_BITS (FRACTION_BITS),
        .DW            (DW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .action    (s_tuser),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .side      (f_side),
        .cvt       (f_cvt),
        .prod      (f_prod),
        .dividend  (f_dividend),
        .divisor   (f_divisor)
    );

    fxalu_round #(
        .FRACTION_BITS (FRACTION_BITS),
        .DW            (DW)
    ) u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (f_valid),
        .in_ready     (f_ready),
        .side_in      (f_side),
        .cvt          (f_cvt),
        .prod         (f_prod),
        .dividend_in  (f_dividend),
        .divisor_in   (f_divisor),
        .out_valid    (c_valid[0]),
        .out_ready    (c_ready[0]),
        .side_out     (c_side[0]),
        .dividend_out (c_dq[0]),
        .divisor_out  (c_dv[0])
    );

    assign c_rem[0] = '0;

    for (genvar g = 0; g < DW; g++)
    begin : g_cell
        fxalu_div_cell #(
            .DW (DW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (c_valid[g]),
            .in_ready    (c_ready[g]),
            .side_in     (c_side[g]),
            .rem_in      (c_rem[g]),
            .dq_in       (c_dq[g]),
            .divisor_in  (c_dv[g]),
            .out_valid   (c_valid[g+1]),
            .out_ready   (c_ready[g+1]),
            .side_out    (c_side[g+1]),
            .rem_out     (c_rem[g+1]),
            .dq_out      (c_dq[g+1]),
            .divisor_out (c_dv[g+1])
        );
    end

    assign c_ready[DW] = !o_valid_reg || m_tready;

    // quotient sign fix-up, low 32 bits kept
    always_comb
    begin
        quot = c_side[DW].neg ? (32'd0 - c_dq[DW][31:0]) : c_dq[DW][31:0];
        o_data_next = {3'b000, c_side[DW].status, c_side[DW].eq, c_side[DW].lt,
                       c_side[DW].gt,
                       (c_side[DW].is_div ? quot : c_side[DW].result)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (c_ready[DW])
            o_valid_reg <= c_valid[DW];
    end

    always_ff @(posedge clk)
    begin
        if (c_ready[DW] && c_valid[DW])
            o_data_reg <= o_data_next;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

    `FXALU_ASSERT_NOW(a_div0_zero, m_tvalid && m_tdata[36:35] == fxalu_pkg::ST_DIV0,
        m_tdata[31:0] == 32'd0)
    `FXALU_ASSERT_NOW(a_flags_excl, m_tvalid, !(m_tdata[32] && m_tdata[33]))
    `FXALU_ASSERT_NOW(a_eq_excl, m_tvalid && m_tdata[34], !m_tdata[32] && !m_tdata[33])
    `FXALU_ASSERT_NEXT(a_out_hold, o_valid_reg && !m_tready, o_valid_reg)

endmodule

// ===== src/fxalu_front.sv =====
module fxalu_front #(
    parameter int FRACTION_BITS = fxalu_pkg::FRAC_BITS_DEF,
    parameter int DW            = 32 + FRACTION_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           action,
    input  logic [31:0]          operand_a,
    input  logic [31:0]          operand_b,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fxalu_pkg::side_t     side,
    output fxalu_pkg::cvt_t      cvt,
    output logic [63:0]          prod,
    output logic [DW-1:0]        dividend,
    output logic [31:0]          divisor
);

    logic                 valid_reg;
    fxalu_pkg::side_t     side_reg, side_next;
    fxalu_pkg::cvt_t      cvt_reg, cvt_next;
    logic [63:0]          prod_reg;
    logic [DW-1:0]        dividend_reg, dividend_next;
    logic [31:0]          divisor_reg, divisor_next;

    // float-to-fixed temporaries
    logic                 f_neg;
    logic [7:0]           f_ex;
    logic [23:0]          f_m;
    logic signed [10:0]   f_s;
    logic signed [10:0]   f_r;
    logic [63:0]          f_mag;
    logic [63:0]          f_lim;
    logic [31:0]          f_res;
    logic                 f_bad;
    logic [31:0]          abs_a;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        f_neg = operand_a[31];
        f_ex  = operand_a[30:23];
        f_m   = {(f_ex != 8'd0), operand_a[22:0]};
        f_s   = $signed({3'b000, ((f_ex == 8'd0) ? 8'd1 : f_ex)}) - 11'sd150
                + 11'(FRACTION_BITS);
        f_r   = -f_s;
        f_lim = f_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        f_mag = '0;
        f_bad = 1'b0;
        f_res = '0;
        if (f_ex == 8'hFF)
        begin
            f_bad = 1'b1;
            f_res = (operand_a[22:0] != 23'd0) ? 32'h7FFF_FFFF :
                    (f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end
        else if (f_m != 24'd0)
        begin
            if (f_s >= 0)
            begin
                if (f_s > 11'sd39)
                    f_bad = 1'b1;
                else
                    f_mag = {40'd0, f_m} << f_s[5:0];
            end
            else if (f_r < 11'sd26)
            begin
                f_mag = ({40'd0, f_m} + (64'd1 << (f_r[4:0] - 5'd1))) >> f_r[4:0];
            end
            if (f_mag > f_lim)
                f_bad = 1'b1;
            if (f_bad)
                f_res = f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                f_res = f_neg ? (32'd0 - f_mag[31:0]) : f_mag[31:0];
        end
    end

    always_comb
    begin
        abs_a            = operand_a[31] ? (32'd0 - operand_a) : operand_a;
        side_next        = '0;
        side_next.act    = action;
        side_next.gt     = $signed(operand_a) > $signed(operand_b);
        side_next.lt     = $signed(operand_a) < $signed(operand_b);
        side_next.eq     = operand_a == operand_b;
        side_next.neg    = operand_a[31] ^ operand_b[31];
        side_next.status = fxalu_pkg::ST_OK;
        unique case (action)
            fxalu_pkg::ACT_ADD:     side_next.result = operand_a + operand_b;
            fxalu_pkg::ACT_SUB:     side_next.result = operand_a - operand_b;
            fxalu_pkg::ACT_DIV:
            begin
                if (operand_b == 32'd0)
                    side_next.status = fxalu_pkg::ST_DIV0;
                else
                    side_next.is_div = 1'b1;
            end
            fxalu_pkg::ACT_MIN:
                side_next.result = side_next.lt ? operand_a : operand_b;
            fxalu_pkg::ACT_MAX:
                side_next.result = side_next.gt ? operand_a : operand_b;
            fxalu_pkg::ACT_INT2FIX: side_next.result = operand_a << FRACTION_BITS;
            fxalu_pkg::ACT_FLT2FIX:
            begin
                side_next.result = f_res;
                if (f_bad)
                    side_next.status = fxalu_pkg::ST_FLOAT;
            end
            fxalu_pkg::ACT_FIX2INT:
                side_next.result = 32'($signed(operand_a) >>> FRACTION_BITS);
            fxalu_pkg::ACT_INC:     side_next.result = operand_a + 32'd1;
            fxalu_pkg::ACT_DEC:     side_next.result = operand_a - 32'd1;
            default:                side_next.result = '0;
        endcase

        cvt_next.sign = operand_a[31];
        cvt_next.mag  = abs_a;
        cvt_next.zero = (abs_a == 32'd0);
        cvt_next.lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (abs_a[i])
                cvt_next.lead = 5'(i);
        end

        dividend_next = {{(DW-32){1'b0}}, abs_a} << FRACTION_BITS;
        divisor_next  = operand_b[31] ? (32'd0 - operand_b) : operand_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            side_reg     <= side_next;
            cvt_reg      <= cvt_next;
            prod_reg     <= 64'($signed(operand_a) * $signed(operand_b));
            dividend_reg <= dividend_next;
            divisor_reg  <= divisor_next;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign cvt       = cvt_reg;
    assign prod      = prod_reg;
    assign dividend  = dividend_reg;
    assign divisor   = divisor_reg;

endmodule

// ===== src/fxalu_round.sv =====
module fxalu_round #(
    parameter int FRACTION_BITS = fxalu_pkg::FRAC_BITS_DEF,
    parameter int DW            = 32 + FRACTION_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fxalu_pkg::side_t     side_in,
    input  fxalu_pkg::cvt_t      cvt,
    input  logic [63:0]          prod,
    input  logic [DW-1:0]        dividend_in,
    input  logic [31:0]          divisor_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fxalu_pkg::side_t     side_out,
    output logic [DW-1:0]        dividend_out,
    output logic [31:0]          divisor_out
);

    logic                 valid_reg;
    fxalu_pkg::side_t     side_reg, side_next;
    logic [DW-1:0]        dividend_reg;
    logic [31:0]          divisor_reg;

    logic [5:0]           lead;
    logic [4:0]           sh;
    logic [31:0]          rem, half;
    logic [24:0]          mant;
    logic [9:0]           exv;
    logic [31:0]          flt;

    assign in_ready = !valid_reg || out_ready;

    // fixed to float, round to nearest even
    always_comb
    begin
        lead = {1'b0, cvt.lead};
        sh   = '0;
        rem  = '0;
        half = '0;
        if (cvt.lead <= 5'd23)
        begin
            mant = 25'({cvt.mag, 24'd0} >> (6'd1 + lead));
        end
        else
        begin
            sh   = cvt.lead - 5'd23;
            rem  = cvt.mag & ((32'd1 << sh) - 32'd1);
            half = 32'd1 << (sh - 5'd1);
            mant = 25'(cvt.mag >> sh);
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 25'd1;
            if (mant[24])
            begin
                mant = mant >> 1;
                lead = lead + 6'd1;
            end
        end
        exv = {4'd0, lead} + 10'd127 - 10'(FRACTION_BITS);
        flt = cvt.zero ? 32'd0 : {cvt.sign, exv[7:0], mant[22:0]};
    end

    always_comb
    begin
        side_next = side_in;
        if (side_in.act == fxalu_pkg::ACT_MUL)
            side_next.result = 32'($signed(prod) >>> FRACTION_BITS);
        else if (side_in.act == fxalu_pkg::ACT_FIX2FLT)
            side_next.result = flt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            side_reg     <= side_next;
            dividend_reg <= dividend_in;
            divisor_reg  <= divisor_in;
        end
    end

    assign out_valid    = valid_reg;
    assign side_out     = side_reg;
    assign dividend_out = dividend_reg;
    assign divisor_out  = divisor_reg;

endmodule

// ===== src/fxalu_div_cell.sv =====
module fxalu_div_cell #(
    parameter int DW = 32 + fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fxalu_pkg::side_t     side_in,
    input  logic [31:0]          rem_in,
    input  logic [DW-1:0]        dq_in,
    input  logic [31:0]          divisor_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fxalu_pkg::side_t     side_out,
    output logic [31:0]          rem_out,
    output logic [DW-1:0]        dq_out,
    output logic [31:0]          divisor_out
);

    logic                 valid_reg;
    fxalu_pkg::side_t     side_reg;
    logic [31:0]          rem_reg, rem_next;
    logic [DW-1:0]        dq_reg, dq_next;
    logic [31:0]          divisor_reg;
    logic [32:0]          trial;
    logic                 fits;

    assign in_ready = !valid_reg || out_ready;

    // one restoring step: dividend bits leave at the top, quotient bits enter below
    always_comb
    begin
        trial    = {rem_in, dq_in[DW-1]};
        fits     = trial >= {1'b0, divisor_in};
        rem_next = fits ? 32'(trial - {1'b0, divisor_in}) : trial[31:0];
        dq_next  = {dq_in[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            side_reg    <= side_in;
            rem_reg     <= rem_next;
            dq_reg      <= dq_next;
            divisor_reg <= divisor_in;
        end
    end

    assign out_valid   = valid_reg;
    assign side_out    = side_reg;
    assign rem_out     = rem_reg;
    assign dq_out      = dq_reg;
    assign divisor_out = divisor_reg;

endmodule
